// ----- src/rpwq_pkg.sv -----
// ----------------------------------------------------------------------------
// rpwq_pkg
// shared sizes, codes and types of the resource pool with wait queue
// ----------------------------------------------------------------------------
package rpwq_pkg;

  localparam int unsigned MaxRes     = 16;
  localparam int unsigned QueueDepth = 16;

  localparam int unsigned ResIdxW = (MaxRes > 1) ? $clog2(MaxRes) : 1;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);
  localparam int unsigned QIdxW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QueueDepth + 1);

  localparam int unsigned KindW = 2;
  localparam int unsigned NumW  = 8;
  localparam int unsigned RevW  = 32;
  localparam int unsigned IdW   = 16;
  localparam int unsigned StatW = 4;
  localparam int unsigned WaitW = 5;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_ARRIVE  = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  typedef enum logic [StatW-1:0] {
    ST_LOADED       = 4'd0,
    ST_TABLE_FULL   = 4'd1,
    ST_GRANTED      = 4'd2,
    ST_QUEUED       = 4'd3,
    ST_QUEUE_FULL   = 4'd4,
    ST_NO_RESOURCES = 4'd5,
    ST_RELEASED     = 4'd6,
    ST_REGRANTED    = 4'd7,
    ST_ALREADY_FREE = 4'd8,
    ST_NOT_FOUND    = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_MISS,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [NumW-1:0] number;
    logic            free;
    logic [RevW-1:0] revenue;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [ResIdxW-1:0] waddr;
    entry_t             wdata;
    logic [ResIdxW-1:0] raddr;
  } tbl_req_t;

  typedef struct packed {
    logic           push;
    logic           pop;
    logic [IdW-1:0] push_id;
  } fifo_req_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic [IdW-1:0]   head_id;
  } fifo_stat_t;

  typedef struct packed {
    status_e          status;
    logic [NumW-1:0]  number;
    logic [IdW-1:0]   id;
    logic [RevW-1:0]  revenue;
    logic [WaitW-1:0] waiting;
  } result_t;

endpackage

// ----- src/rpwq_table.sv -----
// ----------------------------------------------------------------------------
// rpwq_table
// resource table memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module rpwq_table
  import rpwq_pkg::*;
(
  input  logic     clk_i,
  input  tbl_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [MaxRes];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rpwq_fifo.sv -----
// ----------------------------------------------------------------------------
// rpwq_fifo
// circular wait queue of requester ids with registered head read
// ----------------------------------------------------------------------------
module rpwq_fifo
  import rpwq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fifo_req_t  req_i,
  output fifo_stat_t stat_o
);

  logic [IdW-1:0]   mem [QueueDepth];
  logic [QIdxW-1:0] head_q, head_d;
  logic [QIdxW-1:0] tail_q, tail_d;
  logic [QCntW-1:0] count_q, count_d;
  logic [IdW-1:0]   head_id_q;

  function automatic logic [QIdxW-1:0] wrap_inc(input logic [QIdxW-1:0] p);
    logic [QIdxW-1:0] r;
    if (p == QIdxW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + QIdxW'(1);
    end
    return r;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      tail_d  = wrap_inc(tail_q);
      count_d = count_q + QCntW'(1);
    end else if (req_i.pop) begin
      head_d  = wrap_inc(head_q);
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[tail_q] <= req_i.push_id;
    end
    head_id_q <= mem[head_q];
  end

  assign stat_o.count   = count_q;
  assign stat_o.full    = (count_q == QCntW'(QueueDepth));
  assign stat_o.head_id = head_id_q;

endmodule

// ----- src/rpwq_seq.sv -----
// ----------------------------------------------------------------------------
// rpwq_seq
// sequencer: table scan with one shared compare, saturating add, result stage
// ----------------------------------------------------------------------------
module rpwq_seq
  import rpwq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [NumW-1:0]  resource_number_i,
  input  logic             load_free_i,
  input  logic [RevW-1:0]  load_revenue_i,
  input  logic [RevW-1:0]  release_amount_i,
  output tbl_req_t         tbl_req_o,
  input  entry_t           tbl_rdata_i,
  output fifo_req_t        fifo_req_o,
  input  fifo_stat_t       fifo_stat_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_o
);

  state_e             state_q, state_d;
  kind_e              kind_q, kind_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [RevW-1:0]    amount_q, amount_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [IdW-1:0]     next_id_q, next_id_d;
  logic [ResCntW-1:0] res_count_q, res_count_d;
  logic [ResCntW-1:0] rd_idx_q, rd_idx_d;
  logic               pend_q, pend_d;
  logic [ResIdxW-1:0] chk_idx_q, chk_idx_d;
  logic [ResIdxW-1:0] hit_idx_q, hit_idx_d;
  entry_t             hit_ent_q, hit_ent_d;
  result_t            res_q, res_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic             accept;
  logic             issue;
  logic             hit;
  logic             done_ok;
  logic [RevW:0]    sum_w;
  logic [RevW-1:0]  sum_sat;
  logic [WaitW-1:0] wait_now;

  assign accept   = in_valid_i && in_ready_o;
  assign issue    = (rd_idx_q < res_count_q);
  assign hit      = pend_q && ((kind_q == KIND_ARRIVE) ? tbl_rdata_i.free
                                                       : (tbl_rdata_i.number == num_q));
  assign done_ok  = !out_valid_q || out_ready_i;
  assign sum_w    = {1'b0, hit_ent_q.revenue} + {1'b0, amount_q};
  assign sum_sat  = sum_w[RevW] ? '1 : sum_w[RevW-1:0];
  assign wait_now = WaitW'(fifo_stat_i.count);

  assign in_ready_o = (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_LOAD: state_d = S_DONE;
            KIND_ARRIVE: begin
              state_d = (res_count_q == '0) ? S_DONE : S_SCAN;
            end
            KIND_RELEASE: state_d = S_SCAN;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_HIT;
        end else if (!pend_q && !issue) begin
          state_d = S_MISS;
        end
      end
      S_HIT:  state_d = S_DONE;
      S_MISS: state_d = S_DONE;
      S_DONE: begin
        if (done_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d      = kind_q;
    num_d       = num_q;
    amount_d    = amount_q;
    id_d        = id_q;
    next_id_d   = next_id_q;
    res_count_d = res_count_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    chk_idx_d   = chk_idx_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tbl_req_o   = '{we: 1'b0, waddr: hit_idx_q, wdata: hit_ent_q,
                    raddr: rd_idx_q[ResIdxW-1:0]};
    fifo_req_o  = '{push: 1'b0, pop: 1'b0, push_id: id_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d   = kind_e'(kind_i);
          num_d    = resource_number_i;
          amount_d = release_amount_i;
          rd_idx_d = '0;
          case (kind_i)
            KIND_LOAD: begin
              if (res_count_q >= ResCntW'(MaxRes)) begin
                res_d = '{ST_TABLE_FULL, resource_number_i, '0, '0, wait_now};
              end else begin
                tbl_req_o.we    = 1'b1;
                tbl_req_o.waddr = res_count_q[ResIdxW-1:0];
                tbl_req_o.wdata = '{resource_number_i, load_free_i, load_revenue_i};
                res_count_d     = res_count_q + ResCntW'(1);
                res_d = '{ST_LOADED, resource_number_i, '0, load_revenue_i, wait_now};
              end
            end
            KIND_ARRIVE: begin
              if (res_count_q == '0) begin
                res_d = '{ST_NO_RESOURCES, '0, '0, '0, wait_now};
              end else begin
                id_d      = next_id_q;
                next_id_d = (next_id_q == '1) ? IdW'(1) : next_id_q + IdW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // one table read issued and one entry checked per cycle
        rd_idx_d  = rd_idx_q + ResCntW'(issue);
        pend_d    = issue && !hit;
        chk_idx_d = rd_idx_q[ResIdxW-1:0];
        if (hit) begin
          hit_idx_d = chk_idx_q;
          hit_ent_d = tbl_rdata_i;
        end
      end
      S_HIT: begin
        if (kind_q == KIND_ARRIVE) begin
          tbl_req_o.we    = 1'b1;
          tbl_req_o.wdata = '{hit_ent_q.number, 1'b0, hit_ent_q.revenue};
          res_d = '{ST_GRANTED, hit_ent_q.number, id_q, hit_ent_q.revenue, wait_now};
        end else if (hit_ent_q.free) begin
          res_d = '{ST_ALREADY_FREE, num_q, '0, hit_ent_q.revenue, wait_now};
        end else if (fifo_stat_i.count != '0) begin
          // head of the queue takes the resource straight away
          tbl_req_o.we    = 1'b1;
          tbl_req_o.wdata = '{hit_ent_q.number, 1'b0, sum_sat};
          fifo_req_o.pop  = 1'b1;
          res_d = '{ST_REGRANTED, num_q, fifo_stat_i.head_id, sum_sat,
                    WaitW'(fifo_stat_i.count - QCntW'(1))};
        end else begin
          tbl_req_o.we    = 1'b1;
          tbl_req_o.wdata = '{hit_ent_q.number, 1'b1, sum_sat};
          res_d = '{ST_RELEASED, num_q, '0, sum_sat, wait_now};
        end
      end
      S_MISS: begin
        if (kind_q == KIND_ARRIVE) begin
          if (fifo_stat_i.full) begin
            res_d = '{ST_QUEUE_FULL, '0, id_q, '0, wait_now};
          end else begin
            fifo_req_o.push = 1'b1;
            res_d = '{ST_QUEUED, '0, id_q, '0,
                      WaitW'(fifo_stat_i.count + QCntW'(1))};
          end
        end else begin
          res_d = '{ST_NOT_FOUND, num_q, '0, '0, wait_now};
        end
      end
      S_DONE: begin
        if (done_ok) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_id_q   <= IdW'(1);
      res_count_q <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_id_q   <= next_id_d;
      res_count_q <= res_count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    num_q     <= num_d;
    amount_q  <= amount_d;
    id_q      <= id_d;
    rd_idx_q  <= rd_idx_d;
    chk_idx_q <= chk_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_ent_q <= hit_ent_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- src/resource_pool_with_wait_queue.sv -----
// Sequence: a load, or an arrival on an empty table, goes from idle straight to the done
//   state; an arrival or release scans the table from entry 0 until the entry it looks for
//   (the hit state) or the end of the loaded entries (the miss state), then goes to the
//   done state. The result moves into the output register once that register is free.
// Throughput: one item at a time; the scan reads one table entry a cycle through the
//   single read port of the table memory, and a new item is taken only back in idle.
// Reset: asynchronous, active low; clears the entry count, queue pointers and id
//   counter (next id 1); table and queue contents are left as they are.
// ----------------------------------------------------------------------------
// resource_pool_with_wait_queue
// resource table with first-free allocation and a fifo of waiting requesters
// ----------------------------------------------------------------------------
module resource_pool_with_wait_queue
  import rpwq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [NumW-1:0]  resource_number_i,
  input  logic             load_free_i,
  input  logic [RevW-1:0]  load_revenue_i,
  input  logic [RevW-1:0]  release_amount_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [StatW-1:0] status_o,
  output logic [NumW-1:0]  granted_number_o,
  output logic [IdW-1:0]   requester_id_o,
  output logic [RevW-1:0]  revenue_out_o,
  output logic [WaitW-1:0] waiting_count_o
);

  // table port, queue port and the registered result
  tbl_req_t   tbl_req;
  entry_t     tbl_rdata;
  fifo_req_t  fifo_req;
  fifo_stat_t fifo_stat;
  result_t    result;

  // sequencer: decodes each transfer, walks the table one entry a cycle
  // and applies the grant, queue or release decision at the end
  rpwq_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .resource_number_i (resource_number_i),
    .load_free_i       (load_free_i),
    .load_revenue_i    (load_revenue_i),
    .release_amount_i  (release_amount_i),
    .tbl_req_o         (tbl_req),
    .tbl_rdata_i       (tbl_rdata),
    .fifo_req_o        (fifo_req),
    .fifo_stat_i       (fifo_stat),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_o             (result)
  );

  // resource table: number, free flag and revenue per entry
  rpwq_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  // wait queue of requester ids
  rpwq_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fifo_req),
    .stat_o (fifo_stat)
  );

  // result fields straight from the output register
  assign status_o         = result.status;
  assign granted_number_o = result.number;
  assign requester_id_o   = result.id;
  assign revenue_out_o    = result.revenue;
  assign waiting_count_o  = result.waiting;

endmodule
